// ===== rtl/script_source_tokenizer_unit_macros.svh =====
// Assertion macros shared by the tokenizer RTL
`ifndef SCRIPT_SOURCE_TOKENIZER_UNIT_MACROS_SVH
`define SCRIPT_SOURCE_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sst_pkg.sv =====
// Types, codes and lookup functions of the source tokenizer
`timescale 1ns / 1ps
package sst_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'd0,
        MODE_OP    = 4'd1,
        MODE_IDENT = 4'd2,
        MODE_NUM   = 4'd3,
        MODE_STR   = 4'd4,
        MODE_LINE  = 4'd5,
        MODE_BLOCK = 4'd6
    } scan_mode_t;

    // Token kinds
    localparam logic [5:0] KIND_ERROR  = 6'd0;
    localparam logic [5:0] KIND_NUMBER = 6'd1;
    localparam logic [5:0] KIND_IDENT  = 6'd2;
    localparam logic [5:0] KIND_NULL   = 6'd3;
    localparam logic [5:0] KIND_FUNC   = 6'd4;
    localparam logic [5:0] KIND_RETURN = 6'd5;
    localparam logic [5:0] KIND_CONT   = 6'd6;
    localparam logic [5:0] KIND_BREAK  = 6'd7;
    localparam logic [5:0] KIND_VAR    = 6'd8;
    localparam logic [5:0] KIND_IF     = 6'd9;
    localparam logic [5:0] KIND_ELSE   = 6'd10;
    localparam logic [5:0] KIND_LPAREN = 6'd11;
    localparam logic [5:0] KIND_RPAREN = 6'd12;
    localparam logic [5:0] KIND_LBRACE = 6'd13;
    localparam logic [5:0] KIND_RBRACE = 6'd14;
    localparam logic [5:0] KIND_LBRACK = 6'd15;
    localparam logic [5:0] KIND_RBRACK = 6'd16;
    localparam logic [5:0] KIND_ASSIGN = 6'd17;
    localparam logic [5:0] KIND_EQ     = 6'd18;
    localparam logic [5:0] KIND_PLUS   = 6'd19;
    localparam logic [5:0] KIND_MINUS  = 6'd20;
    localparam logic [5:0] KIND_SLASH  = 6'd21;
    localparam logic [5:0] KIND_STAR   = 6'd22;
    localparam logic [5:0] KIND_PCT    = 6'd23;
    localparam logic [5:0] KIND_LT     = 6'd24;
    localparam logic [5:0] KIND_GT     = 6'd25;
    localparam logic [5:0] KIND_LE     = 6'd26;
    localparam logic [5:0] KIND_GE     = 6'd27;
    localparam logic [5:0] KIND_NE     = 6'd28;
    localparam logic [5:0] KIND_COMMA  = 6'd29;
    localparam logic [5:0] KIND_SEMI   = 6'd30;
    localparam logic [5:0] KIND_FOR    = 6'd31;
    localparam logic [5:0] KIND_WHILE  = 6'd32;
    localparam logic [5:0] KIND_STRING = 6'd33;
    localparam logic [5:0] KIND_AND    = 6'd34;
    localparam logic [5:0] KIND_OR     = 6'd35;
    localparam logic [5:0] KIND_DOT    = 6'd36;
    localparam logic [5:0] KIND_EOF    = 6'd37;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNEXPECT = 2'd1;
    localparam logic [1:0] ERR_UNTERM   = 2'd2;
    localparam logic [1:0] ERR_DOT      = 2'd3;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    localparam int RESULT_BITS = 80;

    typedef struct packed {
        logic        last;
        logic [1:0]  err;
        logic [15:0] col;
        logic [15:0] line;
        logic [15:0] len;
        logic [23:0] pos;
        logic [5:0]  kind;
    } result_t;

    function automatic result_t make_result(input logic [5:0] kind, input logic [23:0] pos,
                                            input logic [15:0] len, input logic [15:0] line,
                                            input logic [15:0] col, input logic [1:0] err);
        result_t r;
        r.kind = kind;
        r.pos  = pos;
        r.len  = len;
        r.line = line;
        r.col  = col;
        r.err  = err;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Kind of a one-byte punctuation token, KIND_ERROR when none
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        case (c)
            8'h2B:   return KIND_PLUS;
            8'h2D:   return KIND_MINUS;
            CH_SLASH: return KIND_SLASH;
            CH_STAR: return KIND_STAR;
            8'h25:   return KIND_PCT;
            CH_EQ:   return KIND_ASSIGN;
            CH_LT:   return KIND_LT;
            CH_GT:   return KIND_GT;
            CH_DOT:  return KIND_DOT;
            8'h2C:   return KIND_COMMA;
            8'h3B:   return KIND_SEMI;
            8'h28:   return KIND_LPAREN;
            8'h29:   return KIND_RPAREN;
            8'h7B:   return KIND_LBRACE;
            8'h7D:   return KIND_RBRACE;
            8'h5B:   return KIND_LBRACK;
            8'h5D:   return KIND_RBRACK;
            default: return KIND_ERROR;
        endcase
    endfunction

    // Keyword match on a zero-padded prefix, first byte lowest
    function automatic logic [5:0] ident_kind(input logic [63:0] p, input logic [15:0] len);
        logic [5:0] k;
        k = KIND_IDENT;
        if (len == 16'd3 && p == 64'h0000_0000_0072_6176) k = KIND_VAR;
        if (len == 16'd4 && p == 64'h0000_0000_636E_7566) k = KIND_FUNC;
        if (len == 16'd2 && p == 64'h0000_0000_0000_6669) k = KIND_IF;
        if (len == 16'd4 && p == 64'h0000_0000_6573_6C65) k = KIND_ELSE;
        if (len == 16'd3 && p == 64'h0000_0000_0072_6F66) k = KIND_FOR;
        if (len == 16'd5 && p == 64'h0000_0065_6C69_6877) k = KIND_WHILE;
        if (len == 16'd6 && p == 64'h0000_6E72_7574_6572) k = KIND_RETURN;
        if (len == 16'd8 && p == 64'h6575_6E69_746E_6F63) k = KIND_CONT;
        if (len == 16'd5 && p == 64'h0000_006B_6165_7262) k = KIND_BREAK;
        if (len == 16'd4 && p == 64'h0000_0000_6C6C_756E) k = KIND_NULL;
        return k;
    endfunction

endpackage

// ===== rtl/sst_core.sv =====
// Scanner state and per-byte token decisions, up to two results per transaction
`timescale 1ns / 1ps
module sst_core #(
    parameter int MAX_NEST_DEPTH = 63,
    parameter int POSITION_BITS  = 24,
    parameter int KEYWORD_BYTES  = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       in_byte,
    input  logic             in_end,
    output sst_pkg::result_t res0,
    output sst_pkg::result_t res1,
    output logic [1:0]       res_cnt
);
    import sst_pkg::*;
    `include "script_source_tokenizer_unit_macros.svh"

    localparam int DW = $clog2(MAX_NEST_DEPTH + 1);
    localparam int PW = KEYWORD_BYTES * 8;

    scan_mode_t               mode_reg, mode_next;
    logic [7:0]               pend_reg, pend_next;
    logic [DW-1:0]            depth_reg, depth_next;
    logic [15:0]              line_reg, line_next, col_reg, col_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next, tpos_reg, tpos_next;
    logic [15:0]              tline_reg, tline_next, tcol_reg, tcol_next;
    logic [PW-1:0]            prefix_reg, prefix_next;
    logic [15:0]              len_reg, len_next;
    logic                     dot_reg, dot_next, halt_reg, halt_next;

    // Byte classes
    logic c_ws, c_opst, c_alpha, c_digit;
    logic [5:0] c_single;
    assign c_ws    = in_byte == CH_CR || in_byte == CH_LF || in_byte == CH_SP
                     || in_byte == CH_TAB;
    assign c_opst  = in_byte == CH_SLASH || in_byte == CH_GT || in_byte == CH_LT
                     || in_byte == CH_EQ || in_byte == CH_BANG || in_byte == CH_AMP
                     || in_byte == CH_BAR;
    assign c_alpha = (in_byte >= 8'h41 && in_byte <= 8'h5A)
                     || (in_byte >= 8'h61 && in_byte <= 8'h7A);
    assign c_digit = in_byte >= 8'h30 && in_byte <= 8'h39;
    assign c_single = single_kind(in_byte);

    // Token held in IDENT, NUM or OP mode
    logic [5:0] fl_kind;
    logic       fl_err;
    result_t    fl_res;
    always_comb
    begin
        fl_kind = KIND_NUMBER;
        fl_err  = 1'b0;
        if (mode_reg == MODE_IDENT)
            fl_kind = ident_kind(prefix_reg[63:0], len_reg);
        else if (mode_reg == MODE_OP)
        begin
            fl_kind = single_kind(pend_reg);
            fl_err  = fl_kind == KIND_ERROR;
        end
        fl_res = make_result(fl_kind, 24'(tpos_reg),
                             (mode_reg == MODE_OP) ? 16'd1 : len_reg,
                             tline_reg, tcol_reg, fl_err ? ERR_UNEXPECT : ERR_NONE);
    end

    // Byte seen between tokens
    logic       fr_err, fr_emit;
    result_t    fr_res;
    assign fr_err  = !c_ws && !c_opst && c_single == KIND_ERROR && !c_alpha && !c_digit
                     && in_byte != CH_QUOTE;
    assign fr_emit = fr_err || (!c_ws && !c_opst && c_single != KIND_ERROR);
    assign fr_res  = make_result(c_single, 24'(pos_reg), 16'd1, line_reg, col_reg,
                                 fr_err ? ERR_UNEXPECT : ERR_NONE);

    // Per-byte state update
    logic    do_flush, do_fresh, one_emit;
    result_t one_res;
    logic    id_cont;
    logic [5:0] pair_kind;
    assign id_cont = c_alpha || c_digit || in_byte == CH_UNDER;

    always_comb
    begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        depth_next  = depth_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        pos_next    = pos_reg;
        tpos_next   = tpos_reg;
        tline_next  = tline_reg;
        tcol_next   = tcol_reg;
        prefix_next = prefix_reg;
        len_next    = len_reg;
        dot_next    = dot_reg;
        halt_next   = halt_reg;
        do_flush    = 1'b0;
        do_fresh    = 1'b0;
        one_emit    = 1'b0;
        one_res     = fr_res;
        pair_kind   = KIND_ERROR;
        res0        = fr_res;
        res1        = fr_res;
        res_cnt     = 2'd0;

        if (take && !halt_reg && in_end)
        begin
            halt_next = 1'b1;
            if (mode_reg == MODE_STR)
            begin
                res0 = make_result(KIND_ERROR, 24'(tpos_reg), 16'd0, tline_reg, tcol_reg,
                                   ERR_UNTERM);
                res_cnt = 2'd1;
            end
            else if (mode_reg == MODE_IDENT || mode_reg == MODE_NUM || mode_reg == MODE_OP)
            begin
                res0 = fl_res;
                res1 = make_result(KIND_EOF, 24'(pos_reg), 16'd0, line_reg, col_reg,
                                   ERR_NONE);
                res_cnt = fl_err ? 2'd1 : 2'd2;
            end
            else
            begin
                res0 = make_result(KIND_EOF, 24'(pos_reg), 16'd0, line_reg, col_reg,
                                   ERR_NONE);
                res_cnt = 2'd1;
            end
        end
        else if (take && !halt_reg)
        begin
            case (mode_reg)
                MODE_OP:
                begin
                    if (in_byte == CH_EQ)
                    begin
                        if (pend_reg == CH_GT) pair_kind = KIND_GE;
                        else if (pend_reg == CH_LT) pair_kind = KIND_LE;
                        else if (pend_reg == CH_EQ) pair_kind = KIND_EQ;
                        else if (pend_reg == CH_BANG) pair_kind = KIND_NE;
                    end
                    else if (in_byte == CH_AMP && pend_reg == CH_AMP) pair_kind = KIND_AND;
                    else if (in_byte == CH_BAR && pend_reg == CH_BAR) pair_kind = KIND_OR;

                    if (pend_reg == CH_SLASH && in_byte == CH_SLASH)
                    begin
                        mode_next = MODE_LINE;
                        pend_next = 8'd0;
                    end
                    else if (pend_reg == CH_SLASH && in_byte == CH_STAR)
                    begin
                        mode_next  = MODE_BLOCK;
                        depth_next = DW'(1);
                        pend_next  = 8'd0;
                    end
                    else if (pair_kind != KIND_ERROR)
                    begin
                        one_emit  = 1'b1;
                        one_res   = make_result(pair_kind, 24'(tpos_reg), 16'd2, tline_reg,
                                                tcol_reg, ERR_NONE);
                        mode_next = MODE_IDLE;
                        pend_next = 8'd0;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_fresh = !fl_err;
                    end
                end
                MODE_IDENT:
                begin
                    if (id_cont)
                    begin
                        for (int i = 0; i < KEYWORD_BYTES; i++)
                        begin
                            if (len_reg == 16'(i))
                                prefix_next[i*8 +: 8] = in_byte;
                        end
                        len_next = sat_inc(len_reg);
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                MODE_NUM:
                begin
                    if (c_digit)
                        len_next = sat_inc(len_reg);
                    else if (in_byte == CH_DOT && dot_reg)
                    begin
                        halt_next = 1'b1;
                        one_emit  = 1'b1;
                        one_res   = make_result(KIND_ERROR, 24'(pos_reg), 16'd0, line_reg,
                                                col_reg, ERR_DOT);
                    end
                    else if (in_byte == CH_DOT)
                    begin
                        dot_next = 1'b1;
                        len_next = sat_inc(len_reg);
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                MODE_STR:
                begin
                    if (in_byte == CH_QUOTE)
                    begin
                        one_emit  = 1'b1;
                        one_res   = make_result(KIND_STRING, 24'(tpos_reg), len_reg,
                                                tline_reg, tcol_reg, ERR_NONE);
                        mode_next = MODE_IDLE;
                    end
                    else
                        len_next = sat_inc(len_reg);
                end
                MODE_LINE:
                begin
                    if (in_byte == CH_LF)
                        mode_next = MODE_IDLE;
                end
                MODE_BLOCK:
                begin
                    if (pend_reg == CH_SLASH && in_byte == CH_STAR)
                    begin
                        if (depth_reg < DW'(MAX_NEST_DEPTH))
                            depth_next = depth_reg + DW'(1);
                        pend_next = 8'd0;
                    end
                    else if (pend_reg == CH_STAR && in_byte == CH_SLASH)
                    begin
                        if (depth_reg != '0)
                            depth_next = depth_reg - DW'(1);
                        pend_next = 8'd0;
                        if (depth_reg <= DW'(1))
                            mode_next = MODE_IDLE;
                    end
                    else
                        pend_next = (in_byte == CH_SLASH || in_byte == CH_STAR)
                                    ? in_byte : 8'd0;
                end
                default:
                    do_fresh = 1'b1;
            endcase

            // Flush first, then treat the byte as a fresh start
            if (do_flush)
            begin
                mode_next = MODE_IDLE;
                pend_next = 8'd0;
                if (fl_err)
                    halt_next = 1'b1;
            end
            if (do_fresh)
            begin
                pend_next  = c_opst ? in_byte : 8'd0;
                tpos_next  = pos_reg;
                tline_next = line_reg;
                tcol_next  = col_reg;
                len_next   = 16'd0;
                if (fr_err)
                    halt_next = 1'b1;
                if (c_ws || fr_emit)
                    mode_next = MODE_IDLE;
                else if (c_opst)
                    mode_next = MODE_OP;
                else if (c_alpha)
                begin
                    mode_next          = MODE_IDENT;
                    prefix_next        = '0;
                    prefix_next[7:0]   = in_byte;
                    len_next           = 16'd1;
                end
                else if (c_digit)
                begin
                    mode_next = MODE_NUM;
                    dot_next  = 1'b0;
                    len_next  = 16'd1;
                end
                else
                begin
                    mode_next = MODE_STR;
                    tpos_next = pos_reg + POSITION_BITS'(1);
                end
            end

            // Gather results in order
            if (one_emit)
            begin
                res0    = one_res;
                res_cnt = 2'd1;
            end
            else if (do_flush)
            begin
                res0    = fl_res;
                res1    = fr_res;
                res_cnt = (do_fresh && fr_emit) ? 2'd2 : 2'd1;
            end
            else if (do_fresh && fr_emit)
            begin
                res0    = fr_res;
                res_cnt = 2'd1;
            end

            // Position, line and column counters
            pos_next = pos_reg + POSITION_BITS'(1);
            if (in_byte == CH_LF)
            begin
                line_next = sat_inc(line_reg);
                col_next  = 16'd1;
            end
            else if (in_byte != CH_CR)
                col_next = sat_inc(col_reg);
        end

        res0.last = res_cnt == 2'd1;
        res1.last = 1'b1;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pend_reg   <= 8'd0;
            depth_reg  <= '0;
            line_reg   <= 16'd1;
            col_reg    <= 16'd1;
            pos_reg    <= '0;
            tpos_reg   <= '0;
            tline_reg  <= 16'd1;
            tcol_reg   <= 16'd1;
            prefix_reg <= '0;
            len_reg    <= 16'd0;
            dot_reg    <= 1'b0;
            halt_reg   <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            depth_reg  <= depth_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            pos_reg    <= pos_next;
            tpos_reg   <= tpos_next;
            tline_reg  <= tline_next;
            tcol_reg   <= tcol_next;
            prefix_reg <= prefix_next;
            len_reg    <= len_next;
            dot_reg    <= dot_next;
            halt_reg   <= halt_next;
        end
    end

    // Checks
    `SST_ASSERT_NEXT(a_halt_sticky, halt_reg, halt_reg, "halt flag cleared without reset")
    `SST_ASSERT_NOW(a_depth_max, 1'b1, depth_reg <= DW'(MAX_NEST_DEPTH), "depth over maximum")
    `SST_ASSERT_NOW(a_no_res_halted, halt_reg || !take, res_cnt == 2'd0, "result while halted")
    `SST_ASSERT_NEXT(a_end_halts, take && in_end, halt_reg, "end of input did not halt")

endmodule

// ===== rtl/sst_fifo.sv =====
// Four-entry result queue, up to two writes and one read per cycle
`timescale 1ns / 1ps
module sst_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  sst_pkg::result_t wr0,
    input  sst_pkg::result_t wr1,
    input  logic [1:0]       wr_cnt,
    output logic             room,
    output sst_pkg::result_t rd,
    output logic             rd_valid,
    input  logic             rd_take
);
    import sst_pkg::*;
    `include "script_source_tokenizer_unit_macros.svh"

    result_t    mem [4];
    logic [1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop      = rd_take && cnt_reg != 3'd0;
    assign room     = cnt_reg <= 3'd2;
    assign rd_valid = cnt_reg != 3'd0;
    assign rd       = mem[rp_reg];

    // Pointer and fill count update
    always_comb
    begin
        wp_next  = wp_reg + wr_cnt;
        rp_next  = rp_reg + {1'b0, pop};
        cnt_next = cnt_reg + {1'b0, wr_cnt} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
            mem[wp_reg] <= wr0;
        if (wr_cnt == 2'd2)
            mem[wp_reg + 2'd1] <= wr1;
    end

    // Checks
    `SST_ASSERT_NOW(a_cnt_max, 1'b1, cnt_reg <= 3'd4, "queue count over depth")
    `SST_ASSERT_NOW(a_no_overflow, wr_cnt == 2'd2, cnt_reg <= 3'd2, "queue overflow")
    `SST_ASSERT_NEXT(a_ptr_track, 1'b1, wp_reg - rp_reg == cnt_reg[1:0],
                     "pointers disagree with count")

endmodule

// ===== rtl/script_source_tokenizer_unit.sv =====
// Top level of the streaming source tokenizer
`timescale 1ns / 1ps
// Takes one source byte per cycle on the slave side while s_tready is high
// (s_tlast marks end of input) and emits tokens on the master side, each
// with kind, start byte position, length, start line and column. A byte can
// give up to two tokens (a finished token plus the one the byte starts); they
// queue in a four-entry result buffer that drains one per cycle while
// m_tready is high, and s_tready drops only while the buffer holds more than
// two entries. After an error or end of input, bytes are still taken but
// give no token until reset.
module script_source_tokenizer_unit #(
    parameter int MAX_NEST_DEPTH = 63,
    parameter int POSITION_BITS  = 24,
    parameter int KEYWORD_BYTES  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // token_kind, start_position, token_length,
                                   // start_line, start_column, error_code
    output logic        m_tlast    // last_of_run
);
    import sst_pkg::*;

    result_t    r0, r1, head;
    logic [1:0] r_cnt;
    logic       take;

    assign take = s_tvalid && s_tready;

    sst_core #(
        .MAX_NEST_DEPTH(MAX_NEST_DEPTH),
        .POSITION_BITS (POSITION_BITS),
        .KEYWORD_BYTES (KEYWORD_BYTES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .in_byte(s_tdata),
        .in_end (s_tlast),
        .res0   (r0),
        .res1   (r1),
        .res_cnt(r_cnt)
    );

    sst_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr0     (r0),
        .wr1     (r1),
        .wr_cnt  (r_cnt),
        .room    (s_tready),
        .rd      (head),
        .rd_valid(m_tvalid),
        .rd_take (m_tready)
    );

    // Pack result fields, first field lowest
    assign m_tdata = {head.err, head.col, head.line, head.len, head.pos, head.kind};
    assign m_tlast = head.last;

endmodule
